@@ rtl/plni_pkg.sv @@
// ----------------------------------------------------------------------------
// plni_pkg
// Shared widths, register indexes and pipeline types for the periodic
// lattice neighbor index block.
// ----------------------------------------------------------------------------
`default_nettype none

package plni_pkg;

	localparam int AXES            = 4;
	localparam int IDX_W           = 32;
	localparam int SIDE_W          = 9;
	localparam int COORD_W         = 8;
	localparam int DIMS_W          = 3;
	localparam int DIR_W           = 2;
	localparam int STRIDE_W        = IDX_W + 1;
	localparam int REG_IDX_W       = 3;
	localparam int STEPS           = 8;
	localparam int STAGES_PER_AXIS = IDX_W / STEPS;
	localparam int SETTLE          = AXES + 2;
	localparam int SETTLE_W        = 3;

	localparam logic [REG_IDX_W-1:0] REG_NUM_DIMS = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SIDE_0   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SIDE_1   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SIDE_2   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SIDE_3   = 3'd4;

	// Lattice geometry as seen by the datapath, derived from the registers.
	typedef struct packed {
		logic                                  settled;
		logic [DIMS_W-1:0]                     dims;
		logic [AXES-1:0][SIDE_W-1:0]           side;
		logic [AXES:0][STRIDE_W-1:0]           stride;
		logic [AXES-1:0][IDX_W-1:0]            wrap;
		logic [STRIDE_W-1:0]                   vol;
	} cfg_t;

	// One site on its way through the radix decomposition.
	typedef struct packed {
		logic [IDX_W-1:0]                      idx;
		logic [IDX_W-1:0]                      rest;
		logic [COORD_W-1:0]                    rem;
		logic [AXES-1:0][COORD_W-1:0]          coord;
		logic                                  err;
	} pipe_t;

endpackage

`default_nettype wire

@@ rtl/periodic_lattice_neighbor_index_top.sv @@
// ----------------------------------------------------------------------------
// Periodic lattice neighbor index
// Throughput: one result beat per cycle while out_stall is low; the output
// stage hands out one direction per beat and takes the next site only with
// the last beat of the current one.
// Reset and every register write hold the input stalled while the geometry settles.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_lattice_neighbor_index_top
	import plni_pkg::*;
#(
	parameter int MAX_DIMS  = 4,
	parameter int SIDE_BITS = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output      logic                  cfg_ready,
	input  wire logic [REG_IDX_W-1:0]  cfg_index,
	input  wire logic [SIDE_W-1:0]     cfg_data,
	input  wire logic                  in_valid,
	output      logic                  in_stall,
	input  wire logic [IDX_W-1:0]      site_index,
	output      logic                  out_valid,
	input  wire logic                  out_stall,
	output      logic [DIR_W-1:0]      direction,
	output      logic [COORD_W-1:0]    coordinate,
	output      logic [IDX_W-1:0]      next_index,
	output      logic [IDX_W-1:0]      prev_index,
	output      logic                  parity,
	output      logic                  last,
	output      logic                  range_error
);

	localparam int NDIM = (MAX_DIMS < AXES) ? MAX_DIMS : AXES;
	localparam int CW   = (SIDE_BITS < COORD_W) ? SIDE_BITS : COORD_W;
	localparam int NDIV = NDIM * STAGES_PER_AXIS;

	cfg_t          cfg;
	logic          adv;
	logic          vld_s1;
	pipe_t         data_s1;
	logic [NDIV:0] stage_vld;
	pipe_t         stage_data [0:NDIV];

	assign cfg_ready = 1'b1;

	plni_cfg #(
		.NDIM (NDIM),
		.CW   (CW)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign in_stall = ~(adv & cfg.settled);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid & cfg.settled;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s1.idx   <= site_index;
			data_s1.rest  <= site_index;
			data_s1.rem   <= '0;
			data_s1.coord <= '0;
			data_s1.err   <= {1'b0, site_index} >= cfg.vol;
		end
	end

	assign stage_vld[0]  = vld_s1;
	assign stage_data[0] = data_s1;

	for (genvar k = 0; k < NDIV; k++) begin : g_div
		plni_div_stage #(
			.AXIS (k / STAGES_PER_AXIS),
			.LAST ((k % STAGES_PER_AXIS) == (STAGES_PER_AXIS - 1))
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.side   (cfg.side[k / STAGES_PER_AXIS]),
			.vld_i  (stage_vld[k]),
			.data_i (stage_data[k]),
			.vld_o  (stage_vld[k+1]),
			.data_o (stage_data[k+1])
		);
	end

	plni_nbr u_nbr (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.vld_i       (stage_vld[NDIV]),
		.data_i      (stage_data[NDIV]),
		.adv         (adv),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.direction   (direction),
		.coordinate  (coordinate),
		.next_index  (next_index),
		.prev_index  (prev_index),
		.parity      (parity),
		.last        (last),
		.range_error (range_error)
	);

`ifndef ASSERT_OFF
	// An out-of-range site gives exactly one zeroed beat.
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> last && direction == '0 &&
			next_index == '0 && prev_index == '0)
		else $error("range error beat is not a lone zeroed last beat");

	// The geometry is rebuilt after a write, so no site may enter meanwhile.
	a_settle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> in_stall)
		else $error("input taken while the geometry is settling");

	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !range_error |-> ({1'b0, direction} < cfg.dims))
		else $error("direction beyond the dimensions in use");

	a_dir_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=>
			out_valid && direction == $past(direction) + 2'd1)
		else $error("directions of a site are not consecutive");
`endif

endmodule

`default_nettype wire

@@ rtl/plni_cfg.sv @@
// ----------------------------------------------------------------------------
// plni_cfg
// Configuration registers and the lattice geometry derived from them:
// clamped sides, strides, wrap offsets and volume, built up register by register.
// ----------------------------------------------------------------------------
`default_nettype none

module plni_cfg
	import plni_pkg::*;
#(
	parameter int NDIM = 4,
	parameter int CW   = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	input  wire logic [REG_IDX_W-1:0]  cfg_index,
	input  wire logic [SIDE_W-1:0]     cfg_data,
	output      cfg_t                  cfg
);

	localparam logic [SIDE_W-1:0] SIDE_CAP = SIDE_W'(1) << CW;
	localparam logic [DIMS_W-1:0] DIMS_CAP = DIMS_W'(NDIM);

	logic [DIMS_W-1:0]            num_dims_q;
	logic [AXES-1:0][SIDE_W-1:0]  side_q;
	logic [DIMS_W-1:0]            dims_q;
	logic [AXES-1:0][SIDE_W-1:0]  sidec_q;
	logic [AXES:0][STRIDE_W-1:0]  stride_q;
	logic [AXES-1:0][IDX_W-1:0]   wrap_q;
	logic [STRIDE_W-1:0]          vol_q;
	logic [SETTLE_W-1:0]          settle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_dims_q <= DIMS_W'(AXES);
			side_q     <= {AXES{SIDE_W'(8)}};
			settle_q   <= SETTLE_W'(SETTLE);
		end else begin
			if (cfg_valid) begin
				settle_q <= SETTLE_W'(SETTLE);
				case (cfg_index)
					REG_NUM_DIMS: num_dims_q <= cfg_data[DIMS_W-1:0];
					REG_SIDE_0:   side_q[0]  <= cfg_data;
					REG_SIDE_1:   side_q[1]  <= cfg_data;
					REG_SIDE_2:   side_q[2]  <= cfg_data;
					REG_SIDE_3:   side_q[3]  <= cfg_data;
					default: ;
				endcase
			end else if (settle_q != '0) begin
				settle_q <= settle_q - SETTLE_W'(1);
			end
		end
	end

	// The geometry is recomputed every cycle; each product depends on the one
	// registered before it, so it settles once a write has passed down the chain.
	always_ff @(posedge clk) begin
		if (num_dims_q == '0)
			dims_q <= DIMS_W'(1);
		else if (num_dims_q > DIMS_CAP)
			dims_q <= DIMS_CAP;
		else
			dims_q <= num_dims_q;
		stride_q[0] <= STRIDE_W'(1);
		for (int d = 0; d < AXES; d++) begin
			if (side_q[d] == '0)
				sidec_q[d] <= SIDE_W'(1);
			else if (side_q[d] > SIDE_CAP)
				sidec_q[d] <= SIDE_CAP;
			else
				sidec_q[d] <= side_q[d];
			stride_q[d+1] <= STRIDE_W'(stride_q[d] * sidec_q[d]);
			wrap_q[d]     <= IDX_W'((sidec_q[d] - SIDE_W'(1)) * stride_q[d][IDX_W-1:0]);
		end
		vol_q <= stride_q[dims_q];
	end

	assign cfg.settled = (settle_q == '0);
	assign cfg.dims    = dims_q;
	assign cfg.side    = sidec_q;
	assign cfg.stride  = stride_q;
	assign cfg.wrap    = wrap_q;
	assign cfg.vol     = vol_q;

endmodule

`default_nettype wire

@@ rtl/plni_div_stage.sv @@
// ----------------------------------------------------------------------------
// plni_div_stage
// One stage of the mixed-radix decomposition: STEPS restoring division steps
// of the running quotient by the side length of one axis.
// ----------------------------------------------------------------------------
`default_nettype none

module plni_div_stage
	import plni_pkg::*;
#(
	parameter int AXIS    = 0,
	parameter bit LAST    = 1'b0
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire logic [SIDE_W-1:0]  side,
	input  wire logic               vld_i,
	input       pipe_t              data_i,
	output      logic               vld_o,
	output      pipe_t              data_o
);

	logic  vld_s1;
	pipe_t data_s1;
	pipe_t data_c;

	always_comb begin
		logic [SIDE_W-1:0]  r;
		logic [IDX_W-1:0]   rest;
		logic [COORD_W-1:0] rem;
		data_c = data_i;
		rest   = data_i.rest;
		rem    = data_i.rem;
		// The dividend shifts out at the top while quotient bits enter below.
		for (int i = 0; i < STEPS; i++) begin
			r    = {rem, rest[IDX_W-1]};
			rest = {rest[IDX_W-2:0], 1'b0};
			if (r >= side) begin
				r       = r - side;
				rest[0] = 1'b1;
			end
			rem = r[COORD_W-1:0];
		end
		data_c.rest = rest;
		data_c.rem  = rem;
		if (LAST) begin
			data_c.coord[AXIS] = rem;
			data_c.rem         = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s1 <= data_c;
		end
	end

	assign vld_o  = vld_s1;
	assign data_o = data_s1;

endmodule

`default_nettype wire

@@ rtl/plni_nbr.sv @@
// ----------------------------------------------------------------------------
// plni_nbr
// Stride products, neighbor index arithmetic and the output stage that hands
// out one result beat per direction of a site (one beat if out of range).
// ----------------------------------------------------------------------------
`default_nettype none

module plni_nbr
	import plni_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input       cfg_t                cfg,
	input  wire logic                vld_i,
	input       pipe_t               data_i,
	output      logic                adv,
	input  wire logic                out_stall,
	output      logic                out_valid,
	output      logic [DIR_W-1:0]    direction,
	output      logic [COORD_W-1:0]  coordinate,
	output      logic [IDX_W-1:0]    next_index,
	output      logic [IDX_W-1:0]    prev_index,
	output      logic                parity,
	output      logic                last,
	output      logic                range_error
);

	logic                          vld_s1;
	logic [IDX_W-1:0]              idx_s1;
	logic                          err_s1;
	logic                          par_s1;
	logic [AXES-1:0][COORD_W-1:0]  coord_s1;
	logic [AXES-1:0][IDX_W-1:0]    prod_s1;

	logic                          busy_q;
	logic [DIR_W-1:0]              dir_q;
	logic                          err_q;
	logic                          par_q;
	logic [AXES-1:0][COORD_W-1:0]  coord_q;
	logic [AXES-1:0][IDX_W-1:0]    nxt_q;
	logic [AXES-1:0][IDX_W-1:0]    prv_q;

	logic                          par_c;
	logic [AXES-1:0][IDX_W-1:0]    nxt_c;
	logic [AXES-1:0][IDX_W-1:0]    prv_c;
	logic                          last_c;
	logic                          fire;

	always_comb begin
		par_c = 1'b0;
		for (int d = 0; d < AXES; d++) begin
			if (DIMS_W'(d) < cfg.dims)
				par_c = par_c ^ data_i.coord[d][0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1   <= data_i.idx;
			err_s1   <= data_i.err;
			par_s1   <= par_c;
			coord_s1 <= data_i.coord;
			for (int d = 0; d < AXES; d++)
				prod_s1[d] <= IDX_W'(data_i.coord[d] * cfg.stride[d][IDX_W-1:0]);
		end
	end

	// At the top edge of an axis the forward neighbor wraps to coordinate zero;
	// at coordinate zero the backward neighbor wraps to the top edge.
	always_comb begin
		for (int d = 0; d < AXES; d++) begin
			if ((SIDE_W'(coord_s1[d]) + SIDE_W'(1)) == cfg.side[d])
				nxt_c[d] = idx_s1 - prod_s1[d];
			else
				nxt_c[d] = idx_s1 + cfg.stride[d][IDX_W-1:0];
			if (coord_s1[d] == '0)
				prv_c[d] = idx_s1 + cfg.wrap[d];
			else
				prv_c[d] = idx_s1 - cfg.stride[d][IDX_W-1:0];
		end
	end

	assign last_c = err_q | ((DIMS_W'(dir_q) + DIMS_W'(1)) == cfg.dims);
	assign fire   = busy_q & ~out_stall;
	assign adv    = ~busy_q | (fire & last_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			dir_q  <= '0;
		end else if (adv) begin
			busy_q <= vld_s1;
			dir_q  <= '0;
		end else if (fire) begin
			dir_q  <= dir_q + DIR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_q   <= err_s1;
			par_q   <= par_s1;
			coord_q <= coord_s1;
			nxt_q   <= nxt_c;
			prv_q   <= prv_c;
		end
	end

	assign out_valid   = busy_q;
	assign direction   = dir_q;
	assign coordinate  = err_q ? '0 : coord_q[dir_q];
	assign next_index  = err_q ? '0 : nxt_q[dir_q];
	assign prev_index  = err_q ? '0 : prv_q[dir_q];
	assign parity      = par_q & ~err_q;
	assign last        = last_c;
	assign range_error = err_q;

endmodule

`default_nettype wire
